@@ design/sle_pkg.sv @@
// Shared types and constants for the sequential list engine.
package sle_pkg;

  localparam int DEPTH_DEF     = 64;
  localparam int ELEM_BITS_DEF = 32;
  localparam int FUNC_W        = 3;
  localparam int POS_W         = 7;
  localparam int VAL_W         = 32;
  localparam int STATUS_W      = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT  = 3'd0,
    FN_DELETE  = 3'd1,
    FN_LOCATE  = 3'd2,
    FN_DEL_MIN = 3'd3,
    FN_REVERSE = 3'd4,
    FN_DEL_EQ  = 3'd5,
    FN_DEL_RNG = 3'd6
  } func_t;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BADRANGE = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PASS,
    S_PASS2,
    S_DONE
  } state_t;

  // Broadcast control to every cell of the chain.
  typedef struct packed {
    logic shift_en;
    logic load_en;
  } cell_ctrl_t;

endpackage

@@ design/sle_cell.sv @@
// One storage cell of the element chain.
module sle_cell #(
  parameter int ELEM_BITS = sle_pkg::ELEM_BITS_DEF,
  parameter int CW        = 7,
  parameter int IDX       = 0
) (
  input  logic                   clk,
  input  sle_pkg::cell_ctrl_t    ctrl,
  input  logic [CW-1:0]          q,
  input  logic [ELEM_BITS-1:0]   right_data,
  input  logic [ELEM_BITS-1:0]   load_data,
  output logic [ELEM_BITS-1:0]   data
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  // Cells below q take their right neighbor; cell q may take the load word.
  always_ff @(posedge clk) begin
    if (ctrl.shift_en && (MY_IDX < q)) begin
      data <= right_data;
    end else if (ctrl.load_en && (MY_IDX == q)) begin
      data <= load_data;
    end
  end

endmodule

@@ design/sle_chain.sv @@
// Row of element cells; cell 0 is the head seen by the sequencer.
module sle_chain #(
  parameter int DEPTH     = sle_pkg::DEPTH_DEF,
  parameter int ELEM_BITS = sle_pkg::ELEM_BITS_DEF,
  parameter int CW        = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  sle_pkg::cell_ctrl_t    ctrl,
  input  logic [CW-1:0]          q,
  input  logic [ELEM_BITS-1:0]   load_data,
  output logic [ELEM_BITS-1:0]   head
);

  logic [ELEM_BITS-1:0] cell_data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEM_BITS-1:0] right_data;
    if (i == DEPTH - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_mid
      assign right_data = cell_data[i+1];
    end
    sle_cell #(
      .ELEM_BITS (ELEM_BITS),
      .CW        (CW),
      .IDX       (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .q          (q),
      .right_data (right_data),
      .load_data  (load_data),
      .data       (cell_data[i])
    );
  end

  assign head = cell_data[0];

endmodule

@@ design/sequential_list_engine.sv @@
// Top level: ordered list of signed elements held in a chain of cells, one command at a time.
//
// The list lives in a row of DEPTH cells, element k in cell k, with the
// length in a counter. A command is taken when start is high and busy is
// low, which happens only while the engine is idle. busy then stays high
// through the cycle that carries the result.
// A command not refused walks the list through the head cell (twice for
// delete minimum). Each cycle the head element is examined, and either:
// - it is sent round to the end of the live region (kept);
// - it is dropped, and the region shrinks;
// - it is swapped for another word;
// - it is placed mid-region (reverse).
// An insert puts the new word at the end of the region when the walk
// reaches its position. Once the walk is over, the list is back in order.
// Steps per transaction, from the accepting edge up to and including the
// cycle with done high:
// - most commands: the walk, the end of the walk, then done;
// - a good insert also places the word in an extra step;
// - delete minimum needs a search walk and then a replace
//   walk;
// - commands refused up front (bad position, full, empty, bad
//   range, unused code) go straight to done.
// The result appears with done high for exactly one cycle and the
// receiver cannot stall it. busy falls in the cycle after done, so the
// next command is taken no earlier than that cycle.
module sequential_list_engine #(
  parameter int DEPTH     = sle_pkg::DEPTH_DEF,
  parameter int ELEM_BITS = sle_pkg::ELEM_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [sle_pkg::FUNC_W-1:0]          func,
  input  logic [sle_pkg::POS_W-1:0]           position,
  input  logic signed [sle_pkg::VAL_W-1:0]    value,
  input  logic signed [sle_pkg::VAL_W-1:0]    range_high,
  output logic                                done,
  output logic [sle_pkg::STATUS_W-1:0]        status,
  output logic signed [sle_pkg::VAL_W-1:0]    result_value,
  output logic [sle_pkg::POS_W-1:0]           result_position,
  output logic [sle_pkg::POS_W-1:0]           list_length
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > sle_pkg::POS_W) ? CW : sle_pkg::POS_W) + 1;
  localparam logic [CMPW-1:0] DEPTH_X = CMPW'(DEPTH);

  sle_pkg::state_t state, state_next;

  // command registers
  logic [sle_pkg::FUNC_W-1:0]   op;
  logic [sle_pkg::POS_W-1:0]    pos;
  logic signed [ELEM_BITS-1:0]  val;
  logic signed [ELEM_BITS-1:0]  hi;
  // walk control
  logic [CW-1:0]                m;        // live length, kept between commands
  logic [CW-1:0]                n_orig;   // length at command start
  logic [CW-1:0]                j;        // elements walked
  logic                         inserted;
  logic                         found;
  // results and search state
  logic [sle_pkg::STATUS_W-1:0] st;
  logic signed [ELEM_BITS-1:0]  rval;
  logic [CW-1:0]                rpos;
  logic signed [ELEM_BITS-1:0]  minv;
  logic [CW-1:0]                mp;
  logic signed [ELEM_BITS-1:0]  lastv;

  logic signed [ELEM_BITS-1:0]  head;
  sle_pkg::cell_ctrl_t          cctl;
  logic [CW-1:0]                cq;
  logic [ELEM_BITS-1:0]         cdata;

  logic signed [ELEM_BITS-1:0]  val_in;
  logic signed [ELEM_BITS-1:0]  hi_in;
  logic [sle_pkg::STATUS_W-1:0] pre_status;
  logic                         pre_skip;

  logic                         walking;
  logic                         ins_now;
  logic                         proc;
  logic                         drop;
  logic                         rep;
  logic                         pass_end;
  logic [CMPW-1:0]              pos_x;
  logic [CMPW-1:0]              j1_x;

  assign val_in = ELEM_BITS'(value);
  assign hi_in  = ELEM_BITS'(range_high);

  // Up-front checks on the incoming command against the current length.
  always_comb begin
    logic [CMPW-1:0] p_x;
    logic [CMPW-1:0] n_x;
    p_x        = CMPW'(position);
    n_x        = CMPW'(m);
    pre_status = sle_pkg::ST_OK;
    pre_skip   = 1'b0;
    unique case (func)
      sle_pkg::FN_INSERT: begin
        if (p_x == '0 || p_x > n_x + CMPW'(1)) begin
          pre_status = sle_pkg::ST_BADPOS;
          pre_skip   = 1'b1;
        end else if (n_x >= DEPTH_X) begin
          pre_status = sle_pkg::ST_FULL;
          pre_skip   = 1'b1;
        end
      end
      sle_pkg::FN_DELETE: begin
        if (p_x == '0 || p_x > n_x) begin
          pre_status = sle_pkg::ST_BADPOS;
          pre_skip   = 1'b1;
        end
      end
      sle_pkg::FN_DEL_MIN: begin
        if (m == '0) begin
          pre_status = sle_pkg::ST_EMPTY;
          pre_skip   = 1'b1;
        end
      end
      sle_pkg::FN_DEL_RNG: begin
        if (m == '0 || val_in >= hi_in) begin
          pre_status = sle_pkg::ST_BADRANGE;
          pre_skip   = 1'b1;
        end
      end
      sle_pkg::FN_LOCATE, sle_pkg::FN_REVERSE, sle_pkg::FN_DEL_EQ: begin
        pre_skip = 1'b0;
      end
      default: begin
        pre_skip = 1'b1;   // unused code: nothing to do
      end
    endcase
  end

  // Per-cycle walk decisions.
  assign walking  = (state == sle_pkg::S_PASS) || (state == sle_pkg::S_PASS2);
  assign pos_x    = CMPW'(pos);
  assign j1_x     = CMPW'(j) + CMPW'(1);
  assign ins_now  = (op == sle_pkg::FN_INSERT) && !inserted && (pos_x == j1_x);
  assign proc     = (j < n_orig);
  assign pass_end = !ins_now && !proc;

  always_comb begin
    drop = 1'b0;
    if (state == sle_pkg::S_PASS2) begin
      drop = (j == n_orig - CW'(1));
    end else begin
      unique case (op)
        sle_pkg::FN_DELETE:  drop = (pos_x == j1_x);
        sle_pkg::FN_DEL_EQ:  drop = (head == val);
        sle_pkg::FN_DEL_RNG: drop = (head >= val) && (head <= hi);
        default:             drop = 1'b0;
      endcase
    end
  end

  assign rep = (state == sle_pkg::S_PASS2) && (j == mp) && !drop;

  // Chain drive.
  always_comb begin
    cctl  = '0;
    cq    = m - CW'(1);
    cdata = head;
    if (walking) begin
      if (ins_now) begin
        cctl.load_en = 1'b1;   // append new word at end of region
        cq           = m;
        cdata        = val;
      end else if (proc) begin
        cctl.shift_en = 1'b1;
        cctl.load_en  = !drop;
        if (op == sle_pkg::FN_REVERSE) begin
          cq = n_orig - CW'(1) - j;
        end
        if (rep) begin
          cdata = lastv;
        end
      end
    end
  end

  sle_chain #(
    .DEPTH     (DEPTH),
    .ELEM_BITS (ELEM_BITS),
    .CW        (CW)
  ) u_chain (
    .clk       (clk),
    .ctrl      (cctl),
    .q         (cq),
    .load_data (cdata),
    .head      (head)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      sle_pkg::S_IDLE: begin
        if (start) begin
          state_next = pre_skip ? sle_pkg::S_DONE : sle_pkg::S_PASS;
        end
      end
      sle_pkg::S_PASS: begin
        if (pass_end) begin
          state_next = (op == sle_pkg::FN_DEL_MIN) ? sle_pkg::S_PASS2 : sle_pkg::S_DONE;
        end
      end
      sle_pkg::S_PASS2: begin
        if (pass_end) begin
          state_next = sle_pkg::S_DONE;
        end
      end
      sle_pkg::S_DONE: begin
        state_next = sle_pkg::S_IDLE;
      end
      default: begin
        state_next = sle_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    busy            = (state != sle_pkg::S_IDLE);
    done            = (state == sle_pkg::S_DONE);
    status          = st;
    result_value    = sle_pkg::VAL_W'(rval);
    result_position = sle_pkg::POS_W'(rpos);
    list_length     = sle_pkg::POS_W'(m);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sle_pkg::S_IDLE;
      m        <= '0;
      n_orig   <= '0;
      j        <= '0;
      inserted <= 1'b0;
      found    <= 1'b0;
      op       <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        sle_pkg::S_IDLE: begin
          if (start) begin
            op       <= func;
            pos      <= position;
            val      <= val_in;
            hi       <= hi_in;
            n_orig   <= m;
            j        <= '0;
            inserted <= 1'b0;
            found    <= 1'b0;
            st       <= pre_status;
            rval     <= '0;
            rpos     <= '0;
          end
        end
        sle_pkg::S_PASS, sle_pkg::S_PASS2: begin
          if (ins_now) begin
            inserted <= 1'b1;
            m        <= m + CW'(1);
          end else if (proc) begin
            j <= j + CW'(1);
            if (drop) begin
              m <= m - CW'(1);
            end
            if (state == sle_pkg::S_PASS) begin
              if (op == sle_pkg::FN_DELETE && drop) begin
                rval <= head;
              end
              if (op == sle_pkg::FN_LOCATE && !found && head == val) begin
                found <= 1'b1;
                rpos  <= j + CW'(1);
              end
              if (op == sle_pkg::FN_DEL_MIN) begin
                if (j == '0 || head < minv) begin
                  minv <= head;
                  mp   <= j;
                end
                if (j == n_orig - CW'(1)) begin
                  lastv <= head;
                end
              end
            end
          end else begin
            // end of a walk
            if (state == sle_pkg::S_PASS) begin
              if (op == sle_pkg::FN_LOCATE && !found) begin
                st <= sle_pkg::ST_NOTFOUND;
              end
              if (op == sle_pkg::FN_DEL_MIN) begin
                j    <= '0;
                rval <= minv;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
